// ===== design/grid_astar_path_search_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the grid path search block
// Implication checks, reset-qualified, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef GRID_ASTAR_PATH_SEARCH_TOP_ASSERT_SVH
`define GRID_ASTAR_PATH_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication.
`define GASP_ASSERT_NOW(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GASP_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/gasp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gasp_pkg
// Types and constants shared by the grid path search block.
// ----------------------------------------------------------------------------
package gasp_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 6;
  localparam int DIM_W    = 7;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int CELL_AW  = ROW_W + COL_W;
  localparam int CNT_W    = CELL_AW + 1;
  localparam int LEN_W    = 12;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 7;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  localparam logic [CFG_IW-1:0] REG_ROWS      = 3'd0;
  localparam logic [CFG_IW-1:0] REG_COLS      = 3'd1;
  localparam logic [CFG_IW-1:0] REG_START_ROW = 3'd2;
  localparam logic [CFG_IW-1:0] REG_START_COL = 3'd3;
  localparam logic [CFG_IW-1:0] REG_GOAL_ROW  = 3'd4;
  localparam logic [CFG_IW-1:0] REG_GOAL_COL  = 3'd5;

  // Per-cell search state.
  typedef struct packed {
    logic visited;
    logic path;
    dir_t parent;
  } cell_t;

  // One open-list entry.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [LEN_W-1:0] g;
  } q_entry_t;

endpackage

// ===== design/gasp_cmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gasp_cmd_if
// Command channel: mode, cell coordinates and obstacle bit.
// ----------------------------------------------------------------------------
interface gasp_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [5:0] cell_row;
  logic [5:0] cell_col;
  logic       blocked_in;

  modport source (output valid, mode, cell_row, cell_col, blocked_in, input ready);
  modport sink (input valid, mode, cell_row, cell_col, blocked_in, output ready);
endinterface

// ===== design/gasp_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gasp_res_if
// Result channel: search outcome and cell query answer.
// ----------------------------------------------------------------------------
interface gasp_res_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [11:0] path_length;
  logic        on_path;
  logic        blocked_out;

  modport source (output valid, found, path_length, on_path, blocked_out, input ready);
  modport sink (input valid, found, path_length, on_path, blocked_out, output ready);
endinterface

// ===== design/gasp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gasp_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gasp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/grid_astar_path_search_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_astar_path_search_top
// A* search on a 4-neighbour grid with Manhattan heuristic.
// ----------------------------------------------------------------------------
// The cmd channel takes one word per command: load a cell's obstacle bit,
// run a search, or query a cell. Every command returns one word on the res
// channel. Registers (grid size, start, goal) are written through the
// cfg_we / cfg_index / cfg_data port; the user must write them only
// while the block is idle, which the block itself does not enforce. A load
// or an unused mode answers in the cycle after acceptance, a query after
// S_QUERY. A search sweeps the per-cell state RAM, one cell per cycle, then
// steps S_POP/S_POPD per open-list pop, S_NB/S_NBD per in-bounds neighbour
// and S_TR/S_TRD per traced cell, paced by the shared per-cell RAM port.
// The open list is kept as two FIFOs, one for the current minimum f and
// one for f + 2, which is all a consistent Manhattan heuristic produces.
// After reset the block runs the same sweep before it takes a command.
// cmd.ready is low while busy and while a result word waits; a stalled
// receiver simply holds the block until the word is taken.
// ----------------------------------------------------------------------------
`include "grid_astar_path_search_top_assert.svh"

module grid_astar_path_search_top
  import gasp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  gasp_cmd_if.sink          cmd,
  gasp_res_if.source        res
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_QUERY, S_INIT, S_POP, S_POPD, S_NB, S_NBD, S_TR, S_TRD
  } state_t;

  state_t state;
  logic   clr_search;
  logic [CELL_AW-1:0] clr_cnt;

  logic [DIM_W-1:0] rows_cfg, cols_cfg, rows_eff, cols_eff;
  logic [ROW_W-1:0] start_row, goal_row, pr, tr_r;
  logic [COL_W-1:0] start_col, goal_col, pc, tr_c;
  logic [LEN_W-1:0] pg, len;
  dir_t dir;

  logic               cur;
  logic [CELL_AW-1:0] head [2];
  logic [CELL_AW-1:0] tail [2];
  logic [CNT_W-1:0]   qcnt [2];

  logic out_valid, out_found, out_on_path, out_blocked;
  logic [LEN_W-1:0] out_len;

  // RAM ports
  logic [CELL_AW-1:0] rd_idx, cell_waddr;
  logic               cell_we, obs_we, obs_rdata;
  cell_t              cell_wdata, cell_rdata;
  logic               q_we [2];
  q_entry_t           q_wdata, q_rdata [2];

  // Neighbour logic
  logic [ROW_W-1:0] nr;
  logic [COL_W-1:0] nc;
  logic             nb_ok, closer, nb_free, push_tgt;
  logic [ROW_W-1:0] par_r;
  logic [COL_W-1:0] par_c;

  logic accept;
  assign accept = cmd.valid && cmd.ready;

  always_comb begin
    nr = pr;
    nc = pc;
    nb_ok = 1'b0;
    closer = 1'b0;
    case (dir)
      DIR_UP: begin
        nr = pr - 1'b1;
        nb_ok = (pr != '0);
        closer = (pr > goal_row);
      end
      DIR_DOWN: begin
        nr = pr + 1'b1;
        nb_ok = ({1'b0, pr} + 7'd1) < rows_eff;
        closer = (pr < goal_row);
      end
      DIR_LEFT: begin
        nc = pc - 1'b1;
        nb_ok = (pc != '0);
        closer = (pc > goal_col);
      end
      DIR_RIGHT: begin
        nc = pc + 1'b1;
        nb_ok = ({1'b0, pc} + 7'd1) < cols_eff;
        closer = (pc < goal_col);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  // A step toward the goal keeps f, a step away raises it by two.
  assign push_tgt = closer ? cur : ~cur;
  assign nb_free  = !obs_rdata && !cell_rdata.visited;

  // Parent of the traced cell is one step against its stored move.
  always_comb begin
    par_r = tr_r;
    par_c = tr_c;
    case (cell_rdata.parent)
      DIR_UP:    par_r = tr_r + 1'b1;
      DIR_DOWN:  par_r = tr_r - 1'b1;
      DIR_LEFT:  par_c = tr_c + 1'b1;
      DIR_RIGHT: par_c = tr_c - 1'b1;
      default:   par_r = tr_r;
    endcase
  end

  always_comb begin
    case (state)
      S_NB:    rd_idx = {nr, nc};
      S_TR:    rd_idx = {tr_r, tr_c};
      default: rd_idx = {cmd.cell_row, cmd.cell_col};
    endcase
  end

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = clr_cnt;
    cell_wdata = '{visited: 1'b0, path: 1'b0, parent: DIR_UP};
    q_we[0]    = 1'b0;
    q_we[1]    = 1'b0;
    q_wdata    = '{row: nr, col: nc, g: pg + 1'b1};
    case (state)
      S_CLEAR: begin
        cell_we = 1'b1;
      end
      S_INIT: begin
        cell_waddr = {start_row, start_col};
        cell_wdata = '{visited: 1'b1, path: 1'b0, parent: DIR_UP};
        q_wdata    = '{row: start_row, col: start_col, g: '0};
        if ({1'b0, start_row} < rows_eff && {1'b0, start_col} < cols_eff) begin
          cell_we = 1'b1;
          q_we[cur] = 1'b1;
        end
      end
      S_NBD: begin
        cell_waddr = {nr, nc};
        cell_wdata = '{visited: 1'b1, path: 1'b0, parent: dir};
        if (nb_free) begin
          cell_we = 1'b1;
          q_we[push_tgt] = 1'b1;
        end
      end
      S_TRD: begin
        cell_we    = 1'b1;
        cell_waddr = {tr_r, tr_c};
        cell_wdata = '{visited: 1'b1, path: 1'b1, parent: cell_rdata.parent};
      end
      default: begin
        cell_we = 1'b0;
      end
    endcase
  end

  // Loads need no bounds check: every 6-bit coordinate addresses a cell of the store.
  assign obs_we = accept && (mode_t'(cmd.mode) == MODE_LOAD);

  gasp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_obs_ram (
    .clk(clk), .we(obs_we), .waddr({cmd.cell_row, cmd.cell_col}),
    .wdata(cmd.blocked_in), .raddr(rd_idx), .rdata(obs_rdata)
  );

  gasp_ram #(.WIDTH($bits(cell_t)), .DEPTH(CELLS)) u_cell_ram (
    .clk(clk), .we(cell_we), .waddr(cell_waddr),
    .wdata(cell_wdata), .raddr(rd_idx), .rdata(cell_rdata)
  );

  for (genvar i = 0; i < 2; i++) begin : g_queue
    gasp_ram #(.WIDTH($bits(q_entry_t)), .DEPTH(CELLS)) u_q_ram (
      .clk(clk), .we(q_we[i]), .waddr(tail[i]),
      .wdata(q_wdata), .raddr(head[i]), .rdata(q_rdata[i])
    );
  end

  assign cmd.ready       = (state == S_IDLE) && !out_valid;
  assign res.valid       = out_valid;
  assign res.found       = out_found;
  assign res.path_length = out_len;
  assign res.on_path     = out_on_path;
  assign res.blocked_out = out_blocked;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_search <= 1'b0;
      clr_cnt    <= '0;
      out_valid  <= 1'b0;
      rows_cfg   <= DIM_W'(MAX_ROWS);
      cols_cfg   <= DIM_W'(MAX_COLS);
      start_row  <= '0;
      start_col  <= '0;
      goal_row   <= '0;
      goal_col   <= '0;
      cur        <= 1'b0;
      head[0]    <= '0;
      head[1]    <= '0;
      tail[0]    <= '0;
      tail[1]    <= '0;
      qcnt[0]    <= '0;
      qcnt[1]    <= '0;
    end else begin
      if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      for (int i = 0; i < 2; i++) begin
        if (q_we[i]) begin
          tail[i] <= tail[i] + 1'b1;
          qcnt[i] <= qcnt[i] + 1'b1;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS:      rows_cfg  <= cfg_data;
          REG_COLS:      cols_cfg  <= cfg_data;
          REG_START_ROW: start_row <= cfg_data[ROW_W-1:0];
          REG_START_COL: start_col <= cfg_data[COL_W-1:0];
          REG_GOAL_ROW:  goal_row  <= cfg_data[ROW_W-1:0];
          REG_GOAL_COL:  goal_col  <= cfg_data[COL_W-1:0];
          default:       rows_cfg  <= rows_cfg;
        endcase
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CELL_AW'(CELLS - 1)) begin
            state <= clr_search ? S_INIT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            out_found   <= 1'b0;
            out_len     <= '0;
            out_on_path <= 1'b0;
            out_blocked <= 1'b0;
            case (mode_t'(cmd.mode))
              MODE_SEARCH: begin
                state      <= S_CLEAR;
                clr_search <= 1'b1;
                clr_cnt    <= '0;
                cur        <= 1'b0;
                head[0]    <= '0;
                head[1]    <= '0;
                tail[0]    <= '0;
                tail[1]    <= '0;
                qcnt[0]    <= '0;
                qcnt[1]    <= '0;
              end
              MODE_QUERY: state <= S_QUERY;
              default:    out_valid <= 1'b1;
            endcase
          end
        end
        S_QUERY: begin
          out_on_path <= cell_rdata.path;
          out_blocked <= obs_rdata;
          out_valid   <= 1'b1;
          state       <= S_IDLE;
        end
        S_INIT: begin
          // The start cell is pushed here and the neighbours in S_NBD; all pushes
          // are bounded by the registered effective grid size.
          if ({1'b0, start_row} < rows_eff && {1'b0, start_col} < cols_eff) begin
            state <= S_POP;
          end else begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_POP: begin
          if (qcnt[cur] == '0) begin
            if (qcnt[~cur] == '0) begin
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end else begin
              cur <= ~cur;
            end
          end else begin
            head[cur] <= head[cur] + 1'b1;
            qcnt[cur] <= qcnt[cur] - 1'b1;
            state     <= S_POPD;
          end
        end
        S_POPD: begin
          pr  <= q_rdata[cur].row;
          pc  <= q_rdata[cur].col;
          pg  <= q_rdata[cur].g;
          dir <= DIR_UP;
          if (q_rdata[cur].row == goal_row && q_rdata[cur].col == goal_col) begin
            tr_r  <= goal_row;
            tr_c  <= goal_col;
            len   <= '0;
            state <= S_TR;
          end else begin
            state <= S_NB;
          end
        end
        S_NB: begin
          if (nb_ok) begin
            state <= S_NBD;
          end else if (dir == DIR_RIGHT) begin
            state <= S_POP;
          end else begin
            dir <= dir_t'(dir + 2'd1);
          end
        end
        S_NBD: begin
          if (dir == DIR_RIGHT) begin
            state <= S_POP;
          end else begin
            dir   <= dir_t'(dir + 2'd1);
            state <= S_NB;
          end
        end
        S_TR: begin
          if (tr_r == start_row && tr_c == start_col) begin
            out_found <= 1'b1;
            out_len   <= len;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_TRD;
          end
        end
        S_TRD: begin
          if (len != '1) begin
            len <= len + 1'b1;
          end
          tr_r  <= par_r;
          tr_c  <= par_c;
          state <= S_TR;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Effective grid size, saturated to the store dimensions.
  always_ff @(posedge clk) begin
    rows_eff <= (rows_cfg > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_cfg;
    cols_eff <= (cols_cfg > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_cfg;
  end

  `GASP_ASSERT_NOW(a_ready_no_pending, clk, rst, cmd.ready, !res.valid,
                   "command accepted while a result word is pending")
  `GASP_ASSERT_NOW(a_queue_bound, clk, rst, 1'b1,
                   ({1'b0, qcnt[0]} + {1'b0, qcnt[1]}) <= (CNT_W + 1)'(CELLS),
                   "open list holds more entries than cells")
  `GASP_ASSERT_NEXT(a_search_not_immediate, clk, rst,
                    accept && (cmd.mode == MODE_SEARCH), !res.valid,
                    "search result appeared before the state sweep")
  `GASP_ASSERT_NEXT(a_load_answers, clk, rst,
                    accept && (cmd.mode == MODE_LOAD), res.valid && !res.found,
                    "load did not answer in the next cycle")

endmodule
